FILE: rtl/ssq_pkg.sv
// Package for the sorted stack priority queue: sizes, status codes and word types.
`timescale 1ns / 1ps
package ssq_pkg;

    // Storage sizes
    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 20;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Fixed field widths of the result word
    localparam int VAL_W  = 20;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                 kind;
        logic [VAL_W-1:0]     value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0]     popped_value;
        logic [STAT_W-1:0]    status;
        logic [OCC_W-1:0]     occupancy;
    } t_out_word;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic                 do_insert;
        logic                 do_pop;
        logic [KEY_WIDTH-1:0] key;
    } t_cell_ctl;

endpackage

FILE: rtl/ssq_cell.sv
// One storage cell of the sorted chain: holds a key and shifts with its neighbors.
`timescale 1ns / 1ps
module ssq_cell
    import ssq_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic                 i_occupied,
    input  logic                 i_prev_lt,
    input  logic [KEY_WIDTH-1:0] i_prev_key,
    input  logic [KEY_WIDTH-1:0] i_next_key,
    output logic                 o_lt,
    output logic [KEY_WIDTH-1:0] o_key
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;

    // Flag a stored key that stays in place on insert
    assign o_lt  = i_occupied && (r_key < i_ctl.key);
    assign o_key = r_key;

    // On insert keep smaller keys, take the new key at the boundary and shift the rest down; on pop shift up
    always_comb begin
        n_key = r_key;
        if (i_ctl.do_insert) begin
            if (!o_lt) begin
                n_key = i_prev_lt ? i_ctl.key : i_prev_key;
            end
        end else if (i_ctl.do_pop) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

FILE: rtl/sorted_stack_priority_queue_top.sv
// Top level of the sorted stack priority queue: cell chain, count and result register.
`timescale 1ns / 1ps
// Minimum priority queue of up to DEPTH keys held in a chain of cells, sorted
// so that cell 0 always holds the smallest key; a new key goes ahead of any
// stored keys equal to it. Each word is an insert or a pop and gives exactly one result word
// with the popped key, a status (ok, pop on empty, insert dropped when full)
// and the occupancy after the operation. Every cell compares its key with
// the new key at once and shifts by one place, so one word is accepted per
// cycle while the input is not stalled; the result is registered and appears
// in the cycle after acceptance. The input stalls only while a finished result
// is itself stalled at the output register.
module sorted_stack_priority_queue_top
    import ssq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    t_out_word            r_out;
    t_out_word            n_out;
    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    t_cell_ctl            ctl;
    logic [DEPTH-1:0]     lt;
    logic [KEY_WIDTH-1:0] keys [DEPTH];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign is_full     = (r_count == CNT_W'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Broadcast the operation to the chain
    always_comb begin
        ctl.key       = KEY_WIDTH'(i_in.value);
        ctl.do_insert = accept && (i_in.kind == OP_INSERT) && !is_full;
        ctl.do_pop    = accept && (i_in.kind == OP_POP) && !is_empty;
    end

    // Build the chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 prev_lt;
        logic [KEY_WIDTH-1:0] prev_key;
        logic [KEY_WIDTH-1:0] next_key;

        if (i == 0) begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_key = ctl.key;
        end else begin : g_mid
            assign prev_lt  = lt[i-1];
            assign prev_key = keys[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_key = keys[i];
        end else begin : g_inner
            assign next_key = keys[i+1];
        end

        ssq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_occupied (CNT_W'(i) < r_count),
            .i_prev_lt  (prev_lt),
            .i_prev_key (prev_key),
            .i_next_key (next_key),
            .o_lt       (lt[i]),
            .o_key      (keys[i])
        );
    end

    // Form the next count and result word
    always_comb begin
        n_count            = r_count;
        n_out.popped_value = '0;
        n_out.status       = ST_OK;
        if (ctl.do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.do_pop) begin
            n_count            = r_count - CNT_W'(1);
            n_out.popped_value = VAL_W'(keys[0]);
        end else if (i_in.kind == OP_INSERT) begin
            n_out.status = ST_FULL;
        end else begin
            n_out.status = ST_EMPTY;
        end
        n_out.occupancy = OCC_W'(n_count);
    end

    // Hold count, result valid and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the sorted stack priority queue: random and directed words.
`timescale 1ns / 1ps
module testbench
    import ssq_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_OPS  = 1100;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        t_in_word word;
        bit       hold_for_drain;
    } t_stim_word;

    typedef struct {
        t_out_word word;
        int        acc_cycle;
    } t_expected_word;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_stall = 1'b0;
    t_in_word  in_word = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    t_stim_word           stim_q[$];
    t_expected_word       expected_results[$];
    logic [KEY_WIDTH-1:0] held_keys[$];

    int cycle_cnt    = 0;
    int accepted_cnt = 0;
    int checked_cnt  = 0;
    int fail_cnt     = 0;

    sorted_stack_priority_queue_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    // Free-running clock, 4 ns period
    initial begin
        forever #2 clk = ~clk;
    end

    // Count cycles and stop a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle in about 37 percent of calls, except in one calm window
    function automatic bit take_gap();
        if (cycle_cnt >= 800 && cycle_cnt < 1400) begin
            return 1'b0;
        end
        return $urandom_range(99) < 37;
    endfunction

    // Apply one word to the mirrored store and return the result it gives.
    // Keys run from largest at index 0 to smallest at the back (the top).
    function automatic t_out_word apply_queue_op(t_in_word w);
        t_out_word r;
        int        pos;
        r        = '0;
        r.status = ST_OK;
        if (w.kind == OP_INSERT) begin
            if (held_keys.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_keys.size() && !(held_keys[pos] < w.value)) begin
                    pos++;
                end
                held_keys.insert(pos, w.value[KEY_WIDTH-1:0]);
            end
        end else begin
            if (held_keys.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped_value = held_keys.pop_back();
            end
        end
        r.occupancy = OCC_W'(held_keys.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, t_out_word exp_w, t_out_word act_w);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
            $display("%s: expected value %h status %0d occ %0d, got value %h status %0d occ %0d",
                     what, exp_w.popped_value, exp_w.status, exp_w.occupancy,
                     act_w.popped_value, act_w.status, act_w.occupancy);
        end
    endtask

    task automatic queue_word(logic kind, logic [VAL_W-1:0] value, bit hold);
        t_stim_word s;
        s.word.kind    = kind;
        s.word.value   = value;
        s.hold_for_drain = hold;
        stim_q.push_back(s);
    endtask

    function automatic logic [VAL_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 5) begin
            return VAL_W'($urandom());
        end else if (sel <= 7) begin
            return VAL_W'($urandom_range(3));
        end else if (sel == 8) begin
            return {VAL_W{1'b1}} - VAL_W'($urandom_range(2));
        end
        return VAL_W'(1) << $urandom_range(VAL_W - 1);
    endfunction

    // Drive words from the pending queue and predict each accepted one
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back('{word: apply_queue_op(in_word),
                                             acc_cycle: cycle_cnt});
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || !in_stall) begin
                // Hold a marked word until every earlier result is back
                if (stim_q.size() != 0 && !take_gap() &&
                    !(stim_q[0].hold_for_drain && (in_valid || accepted_cnt != checked_cnt))) begin
                    in_word  <= stim_q[0].word;
                    in_valid <= 1'b1;
                    stim_q.delete(0);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                // Only words accepted on an earlier edge can have a result now
                if (expected_results.size() == 0 || expected_results[0].acc_cycle == cycle_cnt) begin
                    report_mismatch("unexpected result", '0, out_word);
                end else begin
                    if (expected_results[0].word.popped_value != out_word.popped_value ||
                        expected_results[0].word.status != out_word.status ||
                        expected_results[0].word.occupancy != out_word.occupancy) begin
                        report_mismatch("mismatch", expected_results[0].word, out_word);
                    end
                    expected_results.delete(0);
                    checked_cnt <= checked_cnt + 1;
                end
            end
            out_stall <= take_gap();
        end
    end

    // Build the stimulus, run it and decide the outcome
    initial begin
        int mode;
        int run_len;
        int ins_pct;
        int made;

        // Directed: empty pop, key extremes, duplicates, drain to empty
        queue_word(OP_POP, '0, 1'b0);
        queue_word(OP_INSERT, '0, 1'b0);
        queue_word(OP_INSERT, {VAL_W{1'b1}}, 1'b0);
        queue_word(OP_INSERT, {VAL_W{1'b1}}, 1'b0);
        queue_word(OP_INSERT, '0, 1'b0);
        queue_word(OP_INSERT, 20'h55555, 1'b0);
        queue_word(OP_INSERT, 20'hAAAAA, 1'b0);
        for (int i = 0; i < 6; i++) begin
            queue_word(OP_POP, (i % 2) ? {VAL_W{1'b1}} : '0, 1'b0);
        end
        queue_word(OP_POP, 20'hAAAAA, 1'b0);

        // Random: runs that lean toward filling, draining or neither
        made = 0;
        while (made < RANDOM_OPS) begin
            mode    = $urandom_range(2);
            run_len = $urandom_range(10, 50);
            ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (int i = 0; i < run_len; i++) begin
                if ($urandom_range(99) < ins_pct) begin
                    queue_word(OP_INSERT, pick_key(), (made % 250) == 0);
                end else begin
                    queue_word(OP_POP, VAL_W'($urandom()), (made % 250) == 0);
                end
                made++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid || accepted_cnt != checked_cnt) begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        // Flag results that never arrived
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            fail_cnt += expected_results.size();
        end

        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
